@@ rtl/i2da_pkg.sv @@
// shared constants and helpers for the decimal ascii converter
package i2da_pkg;

  localparam int unsigned VALUE_BITS_DEFAULT = 32;
  localparam int unsigned CHAR_COUNT_W       = 4;
  localparam int unsigned CHAR_W             = 8;
  localparam int unsigned DIGIT_W            = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;

  // interpretation of the input word
  localparam logic MODE_SIGNED   = 1'b0;
  localparam logic MODE_UNSIGNED = 1'b1;

  // double dabble correction: a digit of five or more gets three added before the shift
  function automatic logic [DIGIT_W-1:0] dabble_fix(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

@@ rtl/i2da_dabble_stage.sv @@
// one shift-and-correct step of the binary to bcd pipeline
module i2da_dabble_stage #(
  parameter int unsigned VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT,
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic                                     neg_i,
  input  logic [VALUE_BITS-1:0]                    bin_i,
  input  logic [NUM_DIGITS*i2da_pkg::DIGIT_W-1:0]  bcd_i,
  output logic                                     valid_o,
  output logic                                     neg_o,
  output logic [VALUE_BITS-1:0]                    bin_o,
  output logic [NUM_DIGITS*i2da_pkg::DIGIT_W-1:0]  bcd_o
);

  localparam int unsigned BcdW = NUM_DIGITS * i2da_pkg::DIGIT_W;

  logic            valid_q;
  logic            neg_q;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] fixed;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      fixed[i*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W] =
        i2da_pkg::dabble_fix(bcd_i[i*i2da_pkg::DIGIT_W +: i2da_pkg::DIGIT_W]);
    end
    bcd_d = {fixed[BcdW-2:0], bin_i[VALUE_BITS-1]};
    bin_d = {bin_i[VALUE_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= neg_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// top level: binary word to decimal ascii character stream
//
// input channel: valid_i / stall_o with value_bits_i and mode_i. mode 0 reads the word
// as signed two's complement, mode 1 as unsigned. a transaction is taken at a rising
// edge with valid_i high and stall_o low.
// output channel: valid_o / stall_i with char_code_o, last_o and char_count_o. one
// transaction per character, most significant digit first, a leading '-' for negative
// signed values. the final character has last_o set and char_count_o holding the total
// character count (low 4 bits); on all other characters char_count_o is 0.
// path: a number passes one input register, VALUE_BITS double dabble stages, one digit
// count stage, the character sequencer and the output register before its first
// character is shown.
// throughput: one character leaves per cycle while stall_i is low, so a number holds
// the output while its characters (1 to 11 at 32 bits) leave. the pipeline moves as one
// only when the digit count stage is empty or hands its number to the sequencer, so in
// a steady stream the sequencer takes each number as it emits the last one's final digit.
// reset clears every valid bit; no characters are pending afterwards.
// stall_o is high whenever the pipeline is frozen, that is while the count stage holds
// a number the sequencer cannot take yet; a receiver stall holds the output register
// and the sequencer, so the freeze follows once the count stage is full.
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [VALUE_BITS-1:0]              value_bits_i,
  input  logic                               mode_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [i2da_pkg::CHAR_W-1:0]        char_code_o,
  output logic                               last_o,
  output logic [i2da_pkg::CHAR_COUNT_W-1:0]  char_count_o
);

  // decimal digits needed for the largest magnitude: floor(bits*log10(2)) + 1
  localparam int unsigned NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned DigitW    = i2da_pkg::DIGIT_W;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned IdxW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int unsigned SumW      = IdxW + 2;

  // pipeline advance: everything moves together when the last slot is free or drained
  logic adv;

  // ---------------- input register: sign and magnitude ----------------
  logic                  in_valid_q;
  logic                  in_neg_q, in_neg_d;
  logic [VALUE_BITS-1:0] in_mag_q, in_mag_d;

  always_comb begin
    in_neg_d = (mode_i == i2da_pkg::MODE_SIGNED) && value_bits_i[VALUE_BITS-1];
    // the most negative value negates to itself, which is the right magnitude
    in_mag_d = in_neg_d ? (~value_bits_i + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_bits_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_neg_q <= in_neg_d;
      in_mag_q <= in_mag_d;
    end
  end

  assign stall_o = !adv;

  // ---------------- double dabble chain, one bit per stage ----------------
  logic                  st_valid [VALUE_BITS+1];
  logic                  st_neg   [VALUE_BITS+1];
  logic [VALUE_BITS-1:0] st_bin   [VALUE_BITS+1];
  logic [BcdW-1:0]       st_bcd   [VALUE_BITS+1];

  assign st_valid[0] = in_valid_q;
  assign st_neg[0]   = in_neg_q;
  assign st_bin[0]   = in_mag_q;
  assign st_bcd[0]   = '0;

  for (genvar s = 0; s < VALUE_BITS; s++) begin : g_dabble
    i2da_dabble_stage #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NumDigits)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (st_valid[s]),
      .neg_i   (st_neg[s]),
      .bin_i   (st_bin[s]),
      .bcd_i   (st_bcd[s]),
      .valid_o (st_valid[s+1]),
      .neg_o   (st_neg[s+1]),
      .bin_o   (st_bin[s+1]),
      .bcd_o   (st_bcd[s+1])
    );
  end

  // ---------------- digit count stage ----------------
  logic            cnt_valid_q;
  logic            cnt_neg_q;
  logic [BcdW-1:0] cnt_bcd_q;
  logic [IdxW-1:0] cnt_top_q, cnt_top_d;

  // index of the highest nonzero digit, zero for the value zero
  always_comb begin
    cnt_top_d = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (st_bcd[VALUE_BITS][i*DigitW +: DigitW] != '0) begin
        cnt_top_d = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q <= 1'b0;
    end else if (adv) begin
      cnt_valid_q <= st_valid[VALUE_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_neg_q <= st_neg[VALUE_BITS];
      cnt_bcd_q <= st_bcd[VALUE_BITS];
      cnt_top_q <= cnt_top_d;
    end
  end

  // ---------------- character sequencer ----------------
  logic                              seq_valid_q;
  logic                              seq_neg_q;
  logic [IdxW-1:0]                   seq_idx_q;
  logic [DigitW-1:0]                 seq_dig_q [NumDigits];
  logic [i2da_pkg::CHAR_COUNT_W-1:0] seq_total_q;
  logic [SumW-1:0]                   total_sum;

  logic                              out_valid_q;
  logic [i2da_pkg::CHAR_W-1:0]       out_char_q, out_char_d;
  logic                              out_last_q, out_last_d;
  logic [i2da_pkg::CHAR_COUNT_W-1:0] out_count_q, out_count_d;

  logic out_free;     // output register empty or its character taken this cycle
  logic seq_emit;     // sequencer moves a character into the output register
  logic seq_done;     // this emit is the number's final character
  logic seq_load;     // sequencer takes the next number from the count stage

  assign out_free = !out_valid_q || !stall_i;
  assign seq_emit = seq_valid_q && out_free;
  assign seq_done = seq_emit && !seq_neg_q && (seq_idx_q == '0);
  assign seq_load = !seq_valid_q || seq_done;
  assign adv      = !cnt_valid_q || seq_load;

  // digits plus an optional sign, kept to the low bits of the count field
  assign total_sum = SumW'(cnt_top_q) + SumW'(1) + SumW'(cnt_neg_q);

  always_comb begin
    if (seq_neg_q) begin
      out_char_d  = i2da_pkg::ASCII_MINUS;
      out_last_d  = 1'b0;
      out_count_d = '0;
    end else begin
      out_char_d  = i2da_pkg::ASCII_ZERO | {{(i2da_pkg::CHAR_W-DigitW){1'b0}},
                                            seq_dig_q[seq_idx_q]};
      out_last_d  = (seq_idx_q == '0);
      out_count_d = out_last_d ? seq_total_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      seq_neg_q   <= 1'b0;
      seq_idx_q   <= '0;
    end else if (seq_load) begin
      seq_valid_q <= cnt_valid_q;
      seq_neg_q   <= cnt_neg_q;
      seq_idx_q   <= cnt_top_q;
    end else if (seq_emit) begin
      if (seq_neg_q) begin
        seq_neg_q <= 1'b0;
      end else begin
        seq_idx_q <= seq_idx_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      seq_total_q <= total_sum[i2da_pkg::CHAR_COUNT_W-1:0];
      for (int i = 0; i < NumDigits; i++) begin
        seq_dig_q[i] <= cnt_bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= seq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_emit) begin
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_count_q <= out_count_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign char_code_o  = out_char_q;
  assign last_o       = out_last_q;
  assign char_count_o = out_count_q;

endmodule

@@ rtl/i2da_checker.sv @@
// port-level checks for the decimal ascii converter, bound to the top level
module i2da_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               valid_o,
  input logic                               stall_i,
  input logic [i2da_pkg::CHAR_W-1:0]        char_code_o,
  input logic                               last_o,
  input logic [i2da_pkg::CHAR_COUNT_W-1:0]  char_count_o
);

  // a stalled character stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output transaction dropped while stalled");

  // only the final character carries a count, and it is never zero
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o ? (char_count_o != '0) : (char_count_o == '0)))
    else $error("character count does not match last flag");

  // characters are a minus sign or a decimal digit
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (char_code_o == i2da_pkg::ASCII_MINUS ||
                 (char_code_o >= i2da_pkg::ASCII_ZERO &&
                  char_code_o <= i2da_pkg::ASCII_NINE)))
    else $error("character outside minus and digits");

  // a minus sign is always followed by a digit, never ends the number
  a_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && char_code_o == i2da_pkg::ASCII_MINUS |-> !last_o)
    else $error("minus sign flagged as last character");

  // right after a minus sign is taken, the next character offered is not a second minus
  a_sign_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && char_code_o == i2da_pkg::ASCII_MINUS ##1 valid_o |->
      char_code_o != i2da_pkg::ASCII_MINUS)
    else $error("two minus signs in a row");

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .char_code_o  (char_code_o),
  .last_o       (last_o),
  .char_count_o (char_count_o)
);
